// ----- rtl/core/miu_pkg.sv -----
// shared types, constants and opcodes for the integer execute unit
package miu_pkg;

	localparam logic [31:0] RESET_VECTOR = 32'hbfc00000;
	localparam logic [31:0] EXC_VECTOR   = 32'h00000080;
	localparam logic [31:0] STATUS_RESET = 32'h10900000;
	localparam logic [31:0] CAUSE_SYSCALL = 32'h00000020;
	localparam logic [31:0] REVISION     = 32'h00000002;
	localparam logic [4:0]  SR_STATUS    = 5'd12;
	localparam logic [4:0]  SR_CAUSE     = 5'd13;
	localparam logic [4:0]  SR_EPC       = 5'd14;
	localparam logic [4:0]  SR_PRID      = 5'd15;

	localparam logic [5:0] OP_SPECIAL = 6'd0;
	localparam logic [5:0] OP_REGIMM  = 6'd1;
	localparam logic [5:0] OP_J       = 6'd2;
	localparam logic [5:0] OP_JAL     = 6'd3;
	localparam logic [5:0] OP_BEQ     = 6'd4;
	localparam logic [5:0] OP_BNE     = 6'd5;
	localparam logic [5:0] OP_BLEZ    = 6'd6;
	localparam logic [5:0] OP_BGTZ    = 6'd7;
	localparam logic [5:0] OP_ADDI    = 6'd8;
	localparam logic [5:0] OP_ADDIU   = 6'd9;
	localparam logic [5:0] OP_SLTI    = 6'd10;
	localparam logic [5:0] OP_SLTIU   = 6'd11;
	localparam logic [5:0] OP_ANDI    = 6'd12;
	localparam logic [5:0] OP_ORI     = 6'd13;
	localparam logic [5:0] OP_XORI    = 6'd14;
	localparam logic [5:0] OP_LUI     = 6'd15;
	localparam logic [5:0] OP_COP0    = 6'd16;

	localparam logic [5:0] FN_SLL  = 6'd0;
	localparam logic [5:0] FN_SRL  = 6'd2;
	localparam logic [5:0] FN_SRA  = 6'd3;
	localparam logic [5:0] FN_SLLV = 6'd4;
	localparam logic [5:0] FN_SRLV = 6'd6;
	localparam logic [5:0] FN_SRAV = 6'd7;
	localparam logic [5:0] FN_JR   = 6'd8;
	localparam logic [5:0] FN_JALR = 6'd9;
	localparam logic [5:0] FN_SYSCALL = 6'd12;
	localparam logic [5:0] FN_BREAK = 6'd13;
	localparam logic [5:0] FN_MFHI = 6'd16;
	localparam logic [5:0] FN_MTHI = 6'd17;
	localparam logic [5:0] FN_MFLO = 6'd18;
	localparam logic [5:0] FN_MTLO = 6'd19;
	localparam logic [5:0] FN_MULT = 6'd24;
	localparam logic [5:0] FN_MULTU = 6'd25;
	localparam logic [5:0] FN_DIV  = 6'd26;
	localparam logic [5:0] FN_DIVU = 6'd27;
	localparam logic [5:0] FN_ADD  = 6'd32;
	localparam logic [5:0] FN_ADDU = 6'd33;
	localparam logic [5:0] FN_SUB  = 6'd34;
	localparam logic [5:0] FN_SUBU = 6'd35;
	localparam logic [5:0] FN_AND  = 6'd36;
	localparam logic [5:0] FN_OR   = 6'd37;
	localparam logic [5:0] FN_XOR  = 6'd38;
	localparam logic [5:0] FN_NOR  = 6'd39;
	localparam logic [5:0] FN_SLT  = 6'd42;
	localparam logic [5:0] FN_SLTU = 6'd43;

	localparam logic [4:0] RT_BLTZ   = 5'd0;
	localparam logic [4:0] RT_BGEZ   = 5'd1;
	localparam logic [4:0] RT_BLTZAL = 5'd16;
	localparam logic [4:0] RT_BGEZAL = 5'd17;

	localparam logic [4:0] RS_MF  = 5'd0;
	localparam logic [4:0] RS_MT  = 5'd4;
	localparam logic [4:0] RS_RFE = 5'd16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MULDIV,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture instruction
		logic exec;     // evaluate and commit
		logic md_start; // start iterative multiply/divide
		logic md_step;  // one iteration
		logic md_done;  // write hi/lo from the unit
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_muldiv;
		logic md_last;
	} status_t;

endpackage

// ----- rtl/core/miu_ram.sv -----
// generic single-port write, single registered read ram
module miu_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/core/miu_ctrl.sv -----
// controller state machine: sequences fetch, execute, multiply/divide and output
module miu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  miu_pkg::status_t   sts,
	output miu_pkg::cmd_t      cmd
);
	miu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= miu_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			miu_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = miu_pkg::ST_READ;
				end
			end
			miu_pkg::ST_READ: begin
				if (sts.is_muldiv) begin
					cmd.md_start = 1'b1;
					state_d = miu_pkg::ST_MULDIV;
				end else begin
					state_d = miu_pkg::ST_EXEC;
				end
			end
			miu_pkg::ST_MULDIV: begin
				cmd.md_step = 1'b1;
				if (sts.md_last) begin
					state_d = miu_pkg::ST_EXEC;
				end
			end
			miu_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.md_done = sts.is_muldiv;
				state_d = miu_pkg::ST_OUT;
			end
			miu_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = miu_pkg::ST_READ;
					end else begin
						state_d = miu_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = miu_pkg::ST_IDLE;
		endcase
	end
endmodule

// ----- rtl/core/miu_muldiv.sv -----
// iterative shift-add multiplier and restoring divider, one bit per cycle while step is high
module miu_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        step,
	input  logic [5:0]  funct,
	input  logic [31:0] vs,
	input  logic [31:0] vt,
	output logic        last,
	output logic [63:0] result
);
	logic [4:0]  cnt_q;
	logic        is_div_q, neg_q_q, neg_r_q, zero_q;
	logic [31:0] a_q, b_q, vs_q;
	logic [63:0] acc_q;   // mult: {hi, lo}; div: {rem, quot}
	logic        sgn;
	logic [31:0] abs_a, abs_b;
	logic [32:0] msum;
	logic [32:0] dtrial;
	logic [31:0] rem_sh;
	logic [31:0] q_fin, r_fin, p_hi, p_lo;
	logic [63:0] prod_neg;

	assign sgn = (funct == miu_pkg::FN_MULT) || (funct == miu_pkg::FN_DIV);
	assign abs_a = (sgn && vs[31]) ? (32'd0 - vs) : vs;
	assign abs_b = (sgn && vt[31]) ? (32'd0 - vt) : vt;
	assign last = (cnt_q == 5'd31);

	// multiply step: add b to upper half when the low bit is set, shift right
	assign msum = {1'b0, acc_q[63:32]} + (acc_q[0] ? {1'b0, b_q} : 33'd0);
	// divide step
	assign rem_sh = {acc_q[62:32]};
	assign dtrial = {acc_q[63:32], acc_q[31]} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			is_div_q <= (funct == miu_pkg::FN_DIV) || (funct == miu_pkg::FN_DIVU);
			neg_q_q  <= sgn && (vs[31] ^ vt[31]);
			neg_r_q  <= sgn && vs[31];
			zero_q   <= (vt == 32'd0);
			vs_q     <= vs;
			a_q      <= abs_a;
			b_q      <= abs_b;
			acc_q    <= {32'd0, abs_a};
		end else if (step) begin
			if (is_div_q) begin
				if (!dtrial[32]) acc_q <= {dtrial[31:0], acc_q[30:0], 1'b1};
				else acc_q <= {acc_q[62:31], acc_q[30:0], 1'b0};
			end else begin
				acc_q <= {msum, acc_q[31:1]};
			end
		end
	end

	assign q_fin = neg_q_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
	assign r_fin = neg_r_q ? (32'd0 - acc_q[63:32]) : acc_q[63:32];
	assign prod_neg = 64'd0 - acc_q;
	assign p_hi = neg_q_q ? prod_neg[63:32] : acc_q[63:32];
	assign p_lo = neg_q_q ? prod_neg[31:0] : acc_q[31:0];

	always_comb begin
		if (!is_div_q) begin
			result = {p_hi, p_lo};
		end else if (zero_q) begin
			// divide by zero: lo from sign of dividend when signed
			result = {vs_q, (neg_r_q ? 32'd1 : 32'hffffffff)};
		end else begin
			result = {r_fin, q_fin};
		end
	end

	// a_q and rem_sh kept for visibility of the unit operands
	logic unused_ok;
	assign unused_ok = ^{a_q, rem_sh};
endmodule

// ----- rtl/core/miu_dp.sv -----
// datapath: register files, alu, branch logic, cop0 and result register
module miu_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  miu_pkg::cmd_t    cmd,
	output miu_pkg::status_t sts,
	input  logic [31:0]      instr_word,
	output logic [31:0]      fetch_address,
	output logic [4:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             exception_taken,
	output logic             not_executed
);
	logic [31:0] ir_q, pc_q, btgt_q, hi_q, lo_q;
	logic        bpend_q;
	logic [31:0] sr_status_q, sr_cause_q, sr_epc_q;
	logic [31:0] vs, vt, vs_r, vt_r, c0_r;
	logic [5:0]  op, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [4:0]  rs_ra, rt_ra, rd_ra;
	logic [31:0] npc, immu, imms, baddr, jaddr;
	logic [4:0]  widx;
	logic [31:0] wval;
	logic        take, exc, nx, c0w, rfe;
	logic [31:0] tgt, next;
	logic        gpr_we, c0_we, c0_gen;
	logic        md_last;
	logic [63:0] md_res;
	logic [31:0] c0_val;

	assign op = ir_q[31:26];
	assign rs = ir_q[25:21];
	assign rt = ir_q[20:16];
	assign rd = ir_q[15:11];
	assign sa = ir_q[10:6];
	assign fn = ir_q[5:0];

	// read indices follow the live word while loading, then the held word
	assign rs_ra = cmd.load ? instr_word[25:21] : rs;
	assign rt_ra = cmd.load ? instr_word[20:16] : rt;
	assign rd_ra = cmd.load ? instr_word[15:11] : rd;

	// two read ports as two ram copies written together
	miu_ram #(.Width(32), .Depth(32)) u_gpr_a (
		.clk(clk), .we(gpr_we), .waddr(widx), .wdata(wval),
		.raddr(rs_ra), .rdata(vs_r)
	);
	miu_ram #(.Width(32), .Depth(32)) u_gpr_b (
		.clk(clk), .we(gpr_we), .waddr(widx), .wdata(wval),
		.raddr(rt_ra), .rdata(vt_r)
	);
	// general cop0 storage, also for revision; status, cause and epc are held apart
	miu_ram #(.Width(32), .Depth(32)) u_cop0 (
		.clk(clk), .we(c0_we), .waddr(rd), .wdata(vt),
		.raddr(rd_ra), .rdata(c0_r)
	);

	// reads are captured during load; gpr entry 0 and never-written entries read zero
	logic [31:0] gpr_valid_q, c0_valid_q;
	logic [31:0] vs_s1, vt_s1, c0_s1;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vs_s1 <= '0;
			vt_s1 <= '0;
		end
	end
	assign vs = (rs == 5'd0 || !gpr_valid_q[rs]) ? 32'd0 : vs_r;
	assign vt = (rt == 5'd0 || !gpr_valid_q[rt]) ? 32'd0 : vt_r;
	assign c0_s1 = c0_valid_q[rd] ? c0_r : 32'd0;

	miu_muldiv u_md (
		.clk(clk), .arst_n(arst_n), .start(cmd.md_start), .step(cmd.md_step),
		.funct(fn), .vs(vs), .vt(vt), .last(md_last), .result(md_res)
	);

	assign sts.is_muldiv = (op == miu_pkg::OP_SPECIAL) &&
		(fn == miu_pkg::FN_MULT || fn == miu_pkg::FN_MULTU ||
		 fn == miu_pkg::FN_DIV || fn == miu_pkg::FN_DIVU);
	assign sts.md_last = md_last;

	assign npc = pc_q + 32'd4;
	assign immu = {16'd0, ir_q[15:0]};
	assign imms = {{16{ir_q[15]}}, ir_q[15:0]};
	assign baddr = npc + {imms[29:0], 2'b00};
	assign jaddr = {npc[31:28], ir_q[25:0], 2'b00};

	always_comb begin
		priority case (rd)
			miu_pkg::SR_STATUS: c0_val = sr_status_q;
			miu_pkg::SR_CAUSE:  c0_val = sr_cause_q;
			miu_pkg::SR_EPC:    c0_val = sr_epc_q;
			miu_pkg::SR_PRID:   c0_val = c0_valid_q[rd] ? c0_r : miu_pkg::REVISION;
			default:            c0_val = c0_s1;
		endcase
	end

	always_comb begin
		widx = '0; wval = '0; take = 1'b0; exc = 1'b0; nx = 1'b0;
		tgt = '0; c0w = 1'b0; rfe = 1'b0;
		unique case (op)
			miu_pkg::OP_SPECIAL: begin
				unique case (fn)
					miu_pkg::FN_SLL:  begin widx = rd; wval = vt << sa; end
					miu_pkg::FN_SRL:  begin widx = rd; wval = vt >> sa; end
					miu_pkg::FN_SRA:  begin widx = rd; wval = $signed(vt) >>> sa; end
					miu_pkg::FN_SLLV: begin widx = rd; wval = vt << vs[4:0]; end
					miu_pkg::FN_SRLV: begin widx = rd; wval = vt >> vs[4:0]; end
					miu_pkg::FN_SRAV: begin widx = rd; wval = $signed(vt) >>> vs[4:0]; end
					miu_pkg::FN_JALR: begin
						widx = rd; wval = npc + 32'd4; take = 1'b1; tgt = vs;
					end
					miu_pkg::FN_JR:   begin take = 1'b1; tgt = vs; end
					miu_pkg::FN_SYSCALL: exc = 1'b1;
					miu_pkg::FN_BREAK: ;
					miu_pkg::FN_MFHI: begin widx = rd; wval = hi_q; end
					miu_pkg::FN_MTHI, miu_pkg::FN_MTLO, miu_pkg::FN_MULT,
					miu_pkg::FN_MULTU, miu_pkg::FN_DIV, miu_pkg::FN_DIVU: ;
					miu_pkg::FN_MFLO: begin widx = rd; wval = lo_q; end
					miu_pkg::FN_ADD, miu_pkg::FN_ADDU: begin widx = rd; wval = vs + vt; end
					miu_pkg::FN_SUB, miu_pkg::FN_SUBU: begin widx = rd; wval = vs - vt; end
					miu_pkg::FN_AND: begin widx = rd; wval = vs & vt; end
					miu_pkg::FN_OR:  begin widx = rd; wval = vs | vt; end
					miu_pkg::FN_XOR: begin widx = rd; wval = vs ^ vt; end
					miu_pkg::FN_NOR: begin widx = rd; wval = ~(vs | vt); end
					miu_pkg::FN_SLT: begin
						widx = rd; wval = {31'd0, $signed(vs) < $signed(vt)};
					end
					miu_pkg::FN_SLTU: begin widx = rd; wval = {31'd0, vs < vt}; end
					default: nx = 1'b1;
				endcase
			end
			miu_pkg::OP_REGIMM: begin
				tgt = baddr;
				unique case (rt)
					miu_pkg::RT_BLTZAL: begin
						widx = 5'd31; wval = npc + 32'd4; take = vs[31];
					end
					miu_pkg::RT_BLTZ: take = vs[31];
					miu_pkg::RT_BGEZAL: begin
						widx = 5'd31; wval = npc + 32'd4; take = !vs[31];
					end
					miu_pkg::RT_BGEZ: take = !vs[31];
					default: nx = 1'b1;
				endcase
			end
			miu_pkg::OP_JAL: begin
				widx = 5'd31; wval = npc + 32'd4; take = 1'b1; tgt = jaddr;
			end
			miu_pkg::OP_J:    begin take = 1'b1; tgt = jaddr; end
			miu_pkg::OP_BEQ:  begin take = (vs == vt); tgt = baddr; end
			miu_pkg::OP_BNE:  begin take = (vs != vt); tgt = baddr; end
			miu_pkg::OP_BLEZ: begin take = vs[31] || (vs == 32'd0); tgt = baddr; end
			miu_pkg::OP_BGTZ: begin take = !vs[31] && (vs != 32'd0); tgt = baddr; end
			miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU: begin widx = rt; wval = vs + imms; end
			miu_pkg::OP_SLTI: begin
				widx = rt; wval = {31'd0, $signed(vs) < $signed(imms)};
			end
			miu_pkg::OP_SLTIU: begin widx = rt; wval = {31'd0, vs < imms}; end
			miu_pkg::OP_ANDI: begin widx = rt; wval = vs & immu; end
			miu_pkg::OP_ORI:  begin widx = rt; wval = vs | immu; end
			miu_pkg::OP_XORI: begin widx = rt; wval = vs ^ immu; end
			miu_pkg::OP_LUI:  begin widx = rt; wval = {ir_q[15:0], 16'd0}; end
			miu_pkg::OP_COP0: begin
				if (rs == miu_pkg::RS_MF) begin
					widx = rt; wval = c0_val;
				end else if (rs == miu_pkg::RS_MT) begin
					c0w = 1'b1;
				end else if (rs == miu_pkg::RS_RFE) begin
					rfe = 1'b1;
				end else begin
					nx = 1'b1;
				end
			end
			default: nx = 1'b1;
		endcase
		if (widx == 5'd0) wval = '0;
	end

	assign next = exc ? miu_pkg::EXC_VECTOR : (bpend_q ? btgt_q : npc);
	assign gpr_we = cmd.exec && (widx != 5'd0);
	assign c0_gen = !(rd == miu_pkg::SR_STATUS || rd == miu_pkg::SR_CAUSE ||
		rd == miu_pkg::SR_EPC);
	assign c0_we = cmd.exec && c0w && c0_gen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_q <= '0;
			pc_q <= miu_pkg::RESET_VECTOR;
			bpend_q <= 1'b0;
			btgt_q <= '0;
			hi_q <= '0;
			lo_q <= '0;
			sr_status_q <= miu_pkg::STATUS_RESET;
			sr_cause_q <= '0;
			sr_epc_q <= '0;
			gpr_valid_q <= '0;
			c0_valid_q <= '0;
			fetch_address <= '0;
			dest_index <= '0;
			dest_value <= '0;
			exception_taken <= 1'b0;
			not_executed <= 1'b0;
		end else begin
			if (cmd.load) ir_q <= instr_word;
			if (cmd.md_done) begin
				hi_q <= md_res[63:32];
				lo_q <= md_res[31:0];
			end
			if (cmd.exec) begin
				if (op == miu_pkg::OP_SPECIAL && fn == miu_pkg::FN_MTHI) hi_q <= vs;
				if (op == miu_pkg::OP_SPECIAL && fn == miu_pkg::FN_MTLO) lo_q <= vs;
				if (gpr_we) gpr_valid_q[widx] <= 1'b1;
				if (c0_we) c0_valid_q[rd] <= 1'b1;
				if (c0w && rd == miu_pkg::SR_STATUS) sr_status_q <= vt;
				if (c0w && rd == miu_pkg::SR_CAUSE) sr_cause_q <= vt;
				if (c0w && rd == miu_pkg::SR_EPC) sr_epc_q <= vt;
				if (rfe) sr_status_q <= {sr_status_q[31:4], sr_status_q[5:2]};
				if (exc) begin
					sr_status_q <= {sr_status_q[31:6], sr_status_q[3:0], 2'b00};
					sr_cause_q <= miu_pkg::CAUSE_SYSCALL;
					sr_epc_q <= pc_q;
					bpend_q <= 1'b0;
				end else begin
					bpend_q <= take;
					if (take) btgt_q <= tgt;
				end
				pc_q <= next;
				fetch_address <= next;
				dest_index <= widx;
				dest_value <= wval;
				exception_taken <= exc;
				not_executed <= nx;
			end
		end
	end

	logic unused_ok;
	assign unused_ok = ^{vs_s1, vt_s1};
endmodule

// ----- rtl/core/mips_integer_execute_unit.sv -----
// top level of the mips i integer execute unit
//
// in channel: one instruction word per transaction (instr_word, in_valid/in_ready),
// taken as the word fetched at the address the previous result reported.
// out channel: one result per transaction (fetch_address, dest_index, dest_value,
// exception_taken, not_executed), held in an output register until out_ready.
// an ordinary instruction passes a register-file read state and then an execute state
// that commits into the output register, after which out_valid is raised.
// mult, multu, div and divu also run in the shared one-bit-per-cycle
// multiply/divide unit between the read and execute states.
// a new instruction is not accepted before the current result is taken;
// the next word is accepted in the same cycle the current result is taken.
// reset: general registers and hi/lo read zero, status 0x10900000, revision 2,
// program counter 0xbfc00000, no branch pending.
// a stalled receiver holds the result and the unit accepts nothing meanwhile.
module mips_integer_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] fetch_address,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic        exception_taken,
	output logic        not_executed
);
	miu_pkg::cmd_t    cmd;
	miu_pkg::status_t sts;

	miu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	miu_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.instr_word(instr_word),
		.fetch_address(fetch_address), .dest_index(dest_index),
		.dest_value(dest_value), .exception_taken(exception_taken),
		.not_executed(not_executed)
	);
endmodule
